[rtl/binary_grid_neighbor_count_macros.svh]
// assertion macros for the binary grid neighbor count checker
`ifndef BINARY_GRID_NEIGHBOR_COUNT_MACROS_SVH
`define BINARY_GRID_NEIGHBOR_COUNT_MACROS_SVH

// condition holds at every clock edge out of reset
`define BGNC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BGNC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define BGNC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/bgnc_pkg.sv]
// shared constants and helpers for the binary grid neighbor count block
`default_nettype none

package bgnc_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int GRID_RESET     = 1024;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 11;
	localparam int COUNT_W     = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = CFG_INDEX_W'(1);

	localparam logic OP_CELL  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(8);

	function automatic logic [COUNT_W-1:0] popcount8(input logic [7:0] v);
		logic [COUNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + COUNT_W'(v[i]);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

[rtl/binary_grid_neighbor_count.sv]
// accepted items enter stage 1; a result they release then goes to the output register
// throughput: one item per cycle unless the output backs up; the row memory is read on
// accept and written back from stage 1, with a forward path for back-to-back same column
// results lag the stream by one row plus one cell, so each frame needs width + 1 flushes
// reset clears position, window and handshake state; the row memory is not cleared,
// since stored bits are only used after they have been written in the current frame
`default_nettype none

module binary_grid_neighbor_count
	import bgnc_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   opcode,
	input  logic                   cell_marked,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   is_marked,
	output logic [COUNT_W-1:0]     neighbor_count,
	output logic                   row_end,
	output logic                   frame_end,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 2);
	localparam int RST_W = (GRID_RESET > MAX_WIDTH) ? MAX_WIDTH : GRID_RESET;
	localparam int RST_H = (GRID_RESET > MAX_HEIGHT) ? MAX_HEIGHT : GRID_RESET;

	typedef struct packed {
		logic b;
		logic ge1;
		logic ge2;
		logic col0;
		logic res;
		logic last;
	} s1_ctl_t;

	// clamped register values
	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;

	logic [CW-1:0] ic_q;
	logic [RW-1:0] ir_q;
	logic [8:0]    window_q;

	logic          s1_valid_s1;
	s1_ctl_t       s1_ctl_s1;
	logic [CW-1:0] s1_addr_s1;
	logic          s1_fwd_s1;
	logic [1:0]    s1_fwd_data_s1;

	logic               out_valid_q;
	logic               is_marked_q;
	logic [COUNT_W-1:0] count_q;
	logic               row_end_q;
	logic               frame_end_q;

	logic          cfg_we;
	logic          restart;
	logic          accept;
	logic          s1_adv;
	s1_ctl_t       ctl_s0;
	logic [RW-1:0] h_ext;
	logic [RW-1:0] h_p1;
	logic [WW-1:0] ic_inc;
	logic          wrap;
	logic [1:0]    ram_rdata;
	logic [1:0]    st;
	logic          top;
	logic          mid;
	logic [2:0]    col;
	logic [1:0]    wdata;
	logic [8:0]    win;
	logic          center;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign restart   = cfg_we && (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(RST_W);
			h_q <= HW'(RST_H);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_WIDTH: begin
					if (cfg_data == '0) begin
						w_q <= WW'(1);
					end else if (32'(cfg_data) > MAX_WIDTH) begin
						w_q <= WW'(MAX_WIDTH);
					end else begin
						w_q <= WW'(cfg_data);
					end
				end
				REG_GRID_HEIGHT: begin
					if (cfg_data == '0) begin
						h_q <= HW'(1);
					end else if (32'(cfg_data) > MAX_HEIGHT) begin
						h_q <= HW'(MAX_HEIGHT);
					end else begin
						h_q <= HW'(cfg_data);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// handshake
	assign s1_adv   = s1_valid_s1 && (!s1_ctl_s1.res || !out_valid_q || !out_stall);
	assign in_stall = s1_valid_s1 && !s1_adv;
	assign accept   = in_valid && !in_stall;

	// stage 0: position decode on the incoming item
	assign h_ext  = RW'(h_q);
	assign h_p1   = h_ext + RW'(1);
	assign ic_inc = WW'(ic_q) + WW'(1);
	assign wrap   = ic_inc >= w_q;

	always_comb begin
		ctl_s0.b    = (opcode == OP_CELL) && (ir_q < h_ext) && cell_marked;
		ctl_s0.ge1  = ir_q >= RW'(1);
		ctl_s0.ge2  = ir_q >= RW'(2);
		ctl_s0.col0 = ic_q == '0;
		// first column closes the previous row, otherwise the column to the left
		ctl_s0.res  = ctl_s0.col0 ? (ctl_s0.ge2 && ir_q <= h_p1)
			: (ctl_s0.ge1 && ir_q <= h_ext);
		ctl_s0.last = ctl_s0.col0 && ir_q == h_p1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ic_q <= '0;
			ir_q <= '0;
		end else if (restart) begin
			ic_q <= '0;
			ir_q <= '0;
		end else if (accept) begin
			priority if (ctl_s0.last) begin
				ic_q <= '0;
				ir_q <= '0;
			end else if (wrap) begin
				ic_q <= '0;
				ir_q <= ir_q + RW'(1);
			end else begin
				ic_q <= ic_inc[CW-1:0];
			end
		end
	end

	bgnc_ram #(
		.WIDTH(2),
		.DEPTH(MAX_WIDTH)
	) u_row_ram (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(s1_addr_s1),
		.wdata(wdata),
		.re   (accept),
		.raddr(ic_q),
		.rdata(ram_rdata)
	);

	// stage 1: merge the column with the stored rows and slide the window
	assign st     = s1_fwd_s1 ? s1_fwd_data_s1 : ram_rdata;
	assign top    = s1_ctl_s1.ge2 && st[1];
	assign mid    = s1_ctl_s1.ge1 && st[0];
	assign col    = {s1_ctl_s1.b, mid, top};
	assign wdata  = {mid, s1_ctl_s1.b};
	assign win    = s1_ctl_s1.col0 ? {3'b000, window_q[8:3]} : {col, window_q[8:3]};
	assign center = win[4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_ctl_s1      <= ctl_s0;
			s1_addr_s1     <= ic_q;
			// the ram returns old data when the item ahead writes the same column
			s1_fwd_s1      <= s1_adv && s1_addr_s1 == ic_q;
			s1_fwd_data_s1 <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (restart) begin
			window_q <= '0;
		end else if (s1_adv) begin
			if (s1_ctl_s1.col0) begin
				window_q <= s1_ctl_s1.last ? 9'd0 : {col, 6'd0};
			end else begin
				window_q <= win;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && s1_ctl_s1.res) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_ctl_s1.res) begin
			is_marked_q <= center;
			count_q     <= center ? '0 : popcount8({win[8:5], win[3:0]});
			// only the first column item closes a row
			row_end_q   <= s1_ctl_s1.col0;
			frame_end_q <= s1_ctl_s1.last;
		end
	end

	assign out_valid      = out_valid_q;
	assign is_marked      = is_marked_q;
	assign neighbor_count = count_q;
	assign row_end        = row_end_q;
	assign frame_end      = frame_end_q;

endmodule

`default_nettype wire

[rtl/bgnc_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module bgnc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/bgnc_checker.sv]
// port-level checker for the binary grid neighbor count block, with its bind
`default_nettype none

`include "binary_grid_neighbor_count_macros.svh"

module bgnc_checker
	import bgnc_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_stall,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire logic                   is_marked,
	input wire logic [COUNT_W-1:0]     neighbor_count,
	input wire logic                   row_end,
	input wire logic                   frame_end
);

	// a held result keeps its payload
	`BGNC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(is_marked) && $stable(neighbor_count) && $stable(row_end) && $stable(frame_end), "output item changed while stalled")

	// the last cell of a frame is also the last of its row
	`BGNC_ASSERT_ALWAYS(a_frame_row, !out_valid || !frame_end || row_end, "frame end without row end")

	// marked cells report no neighbors and counts stay in range
	`BGNC_ASSERT_ALWAYS(a_count_range, !out_valid || ((!is_marked || neighbor_count == '0) && neighbor_count <= COUNT_MAX), "neighbor count out of range")

	// a fresh result must trace back to an accepted item
	`BGNC_ASSERT_IMPL(a_out_source, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without an accepted item")

endmodule

bind binary_grid_neighbor_count bgnc_checker u_bgnc_checker (.*);

`default_nettype wire

[verif/binary_grid_neighbor_count_checker.sv]
// checker for the grid neighbor count block: tracks the cell stream and compares every result
`timescale 1ns / 100ps

module binary_grid_neighbor_count_checker
	import bgnc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic                   opcode,
	input  logic                   cell_marked,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic                   is_marked,
	input  logic [COUNT_W-1:0]     neighbor_count,
	input  logic                   row_end,
	input  logic                   frame_end,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     mismatch_count,
	output int                     results_owed
);

	typedef struct packed {
		logic               marked;
		logic [COUNT_W-1:0] count;
		logic               row_last;
		logic               frame_last;
	} cell_result_t;

	logic [CFG_DATA_W-1:0] width_reg;
	logic [CFG_DATA_W-1:0] height_reg;
	logic [1:0]            line_store [DEF_MAX_WIDTH];
	logic [8:0]            window;
	int unsigned           col_pos;
	int unsigned           row_pos;
	cell_result_t          owed [$];

	function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] raw,
			input int unsigned ceiling);
		if (raw == 0) return 1;
		if (raw > ceiling) return ceiling;
		return raw;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t checker: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic restart_frame();
		col_pos = 0;
		row_pos = 0;
		window  = '0;
	endtask

	// one accepted item moves the window by one cell and may release the cell behind it
	task automatic advance_grid(input logic op, input logic mark);
		int unsigned  w, h, ir, ic, orow, ocol, n;
		logic         b, upper, middle, emit;
		logic [2:0]   col;
		logic [8:0]   win;
		cell_result_t r;
		w  = clamp_dim(width_reg, DEF_MAX_WIDTH);
		h  = clamp_dim(height_reg, DEF_MAX_HEIGHT);
		ir = row_pos;
		ic = col_pos;
		// marks only count on cell items inside the frame rows
		b      = (op == OP_CELL && ir < h) ? mark : 1'b0;
		upper  = (ir >= 2) ? line_store[ic][1] : 1'b0;
		middle = (ir >= 1) ? line_store[ic][0] : 1'b0;
		col    = {b, middle, upper};
		line_store[ic] = {middle, b};
		if (ic == 0) begin
			// closes the previous row, right column lies outside the grid
			win    = window >> 3;
			emit   = ir >= 2 && ir - 2 < h;
			orow   = ir - 2;
			ocol   = w - 1;
			window = {col, 6'b0};
		end else begin
			win    = (window >> 3) | {col, 6'b0};
			emit   = ir >= 1 && ir - 1 < h;
			orow   = ir - 1;
			ocol   = ic - 1;
			window = win;
		end
		if (ic + 1 >= w) begin
			col_pos = 0;
			row_pos = ir + 1;
		end else begin
			col_pos = ic + 1;
		end
		if (emit) begin
			n = 0;
			for (int i = 0; i < 9; i++) begin
				if (i != 4) n += win[i];
			end
			r.marked     = win[4];
			r.count      = win[4] ? '0 : COUNT_W'(n);
			r.row_last   = ocol == w - 1;
			r.frame_last = r.row_last && orow == h - 1;
			owed.push_back(r);
			if (r.frame_last) restart_frame();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cell_result_t want;
		if (!arst_n) begin
			width_reg  = CFG_DATA_W'(GRID_RESET);
			height_reg = CFG_DATA_W'(GRID_RESET);
			for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
				line_store[i] = '0;
			end
			restart_frame();
			owed.delete();
			mismatch_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (owed.size() == 0) begin
					report_mismatch("result arrived with none owed");
				end else begin
					want = owed.pop_front();
					if (is_marked !== want.marked)
						report_mismatch($sformatf("is_marked got %0b want %0b",
							is_marked, want.marked));
					if (neighbor_count !== want.count)
						report_mismatch($sformatf("neighbor_count got %0d want %0d",
							neighbor_count, want.count));
					if (row_end !== want.row_last)
						report_mismatch($sformatf("row_end got %0b want %0b",
							row_end, want.row_last));
					if (frame_end !== want.frame_last)
						report_mismatch($sformatf("frame_end got %0b want %0b",
							frame_end, want.frame_last));
				end
			end
			if (cfg_valid && cfg_ready) begin
				// any known register write starts a fresh frame
				if (cfg_index == REG_GRID_WIDTH) begin
					width_reg = cfg_data;
					restart_frame();
				end else if (cfg_index == REG_GRID_HEIGHT) begin
					height_reg = cfg_data;
					restart_frame();
				end
			end
			if (in_valid && !in_stall) advance_grid(opcode, cell_marked);
		end
		results_owed = owed.size();
	end

endmodule

[verif/tb_binary_grid_neighbor_count.sv]
// testbench top for the grid neighbor count block: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_binary_grid_neighbor_count;
	import bgnc_pkg::*;

	localparam int unsigned CYCLE_LIMIT    = 1000000;
	localparam int unsigned RANDOM_ITEMS   = 700;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned SQUEEZE_CYCLES = 150;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = '1;
	localparam logic [CFG_DATA_W-1:0]  DIM_TOO_BIG = '1;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic                   opcode;
	logic                   cell_marked;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   is_marked;
	logic [COUNT_W-1:0]     neighbor_count;
	logic                   row_end;
	logic                   frame_end;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int                     mismatch_count;
	int                     results_owed;
	int unsigned            cycle_count = 0;
	int unsigned            items_sent = 0;
	logic [CFG_DATA_W-1:0]  width_raw;
	logic [CFG_DATA_W-1:0]  height_raw;
	bit                     steady_feed = 1'b0;
	bit                     streaming = 1'b0;
	logic                   squeeze = 1'b0;
	int                     stall_left = 0;
	int                     flow_left = 0;

	binary_grid_neighbor_count u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.cell_marked    (cell_marked),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.is_marked      (is_marked),
		.neighbor_count (neighbor_count),
		.row_end        (row_end),
		.frame_end      (frame_end),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	binary_grid_neighbor_count_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.cell_marked    (cell_marked),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.is_marked      (is_marked),
		.neighbor_count (neighbor_count),
		.row_end        (row_end),
		.frame_end      (frame_end),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("tb_binary_grid_neighbor_count: done, errors");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] raw,
			input int unsigned ceiling);
		if (raw == 0) return 1;
		if (raw > ceiling) return ceiling;
		return raw;
	endfunction

	// output side: runs of free flow broken by stalls, plus the long squeeze
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
		end else if (flow_left > 0) begin
			flow_left = flow_left - 1;
		end else begin
			flow_left  = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200)
				: $urandom_range(1, 8);
			stall_left = idle_length();
		end
		out_stall <= squeeze || stall_left > 0;
	end

	// hold the output off long enough for the block to back up into its input
	initial begin
		forever begin
			@(negedge clk);
			if (streaming) begin
				repeat ($urandom_range(50, 400)) @(negedge clk);
				squeeze <= 1'b1;
				repeat (SQUEEZE_CYCLES) @(negedge clk);
				squeeze <= 1'b0;
				repeat (2000) @(negedge clk);
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance with valid still up
	task automatic send_item(input logic op, input logic mark);
		int gap;
		gap = steady_feed ? 0 : idle_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		cell_marked <= mark;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (results_owed != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_grid(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
		settle();
		if ($urandom_range(0, 1)) begin
			write_reg(REG_GRID_WIDTH, w);
			write_reg(REG_GRID_HEIGHT, h);
		end else begin
			write_reg(REG_GRID_HEIGHT, h);
			write_reg(REG_GRID_WIDTH, w);
		end
		cfg_valid <= 1'b0;
		width_raw  = w;
		height_raw = h;
	endtask

	// one full frame plus its flush tail, optionally with stray opcodes mixed in
	task automatic run_frame(input bit noisy);
		int unsigned w, h, cells, density;
		w       = clamp_dim(width_raw, DEF_MAX_WIDTH);
		h       = clamp_dim(height_raw, DEF_MAX_HEIGHT);
		cells   = w * h;
		density = $urandom_range(0, 8);
		steady_feed = ($urandom_range(0, 3) == 0);
		for (int k = 0; k < cells + w + 1; k++) begin
			if (k < cells)
				send_item((noisy && $urandom_range(0, 15) == 0) ? OP_FLUSH : OP_CELL,
					$urandom_range(0, 7) < density);
			else
				send_item((noisy && $urandom_range(0, 15) == 0) ? OP_CELL : OP_FLUSH,
					1'($urandom_range(0, 1)));
		end
		steady_feed = 1'b0;
	endtask

	initial begin
		int unsigned random_start;
		logic [CFG_DATA_W-1:0] w, h;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		opcode      = OP_CELL;
		cell_marked = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_GRID_WIDTH;
		cfg_data    = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// 3x3 ring of marks around an empty center: full count of eight
		set_grid(CFG_DATA_W'(3), CFG_DATA_W'(3));
		for (int k = 0; k < 9; k++) send_item(OP_CELL, k != 4);
		repeat (4) send_item(OP_FLUSH, 1'b0);

		// zero sizes act as one; marked cell, then a flush in cell phase, a cell in flush phase
		set_grid('0, '0);
		send_item(OP_CELL, 1'b1);
		send_item(OP_FLUSH, 1'b1);
		send_item(OP_CELL, 1'b1);
		send_item(OP_FLUSH, 1'b1);
		send_item(OP_CELL, 1'b1);
		send_item(OP_FLUSH, 1'b0);

		// a write to an unmapped index must leave the 1x1 grid alone
		settle();
		write_reg(REG_UNUSED, DIM_TOO_BIG);
		cfg_valid <= 1'b0;
		send_item(OP_CELL, 1'b0);
		send_item(OP_FLUSH, 1'b0);
		send_item(OP_FLUSH, 1'b1);

		// tallest grid, an oversized height saturates
		streaming = 1'b1;
		set_grid('0, DIM_TOO_BIG);
		run_frame(1'b0);

		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			w = ($urandom_range(0, 9) == 0) ? '0
				: CFG_DATA_W'(($urandom_range(0, 4) == 0) ? $urandom_range(17, 64)
				: $urandom_range(1, 16));
			h = ($urandom_range(0, 9) == 0) ? '0
				: CFG_DATA_W'(($urandom_range(0, 4) == 0) ? $urandom_range(9, 24)
				: $urandom_range(1, 8));
			set_grid(w, h);
			repeat ($urandom_range(1, 3)) run_frame($urandom_range(0, 4) == 0);
		end

		in_valid <= 1'b0;
		while (results_owed != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("tb_binary_grid_neighbor_count: done, clean");
		else
			$display("tb_binary_grid_neighbor_count: done, errors");
		$finish;
	end

endmodule

[binary_grid_neighbor_count.f]
+incdir+rtl
rtl/bgnc_pkg.sv
rtl/bgnc_ram.sv
rtl/binary_grid_neighbor_count.sv
rtl/bgnc_checker.sv
verif/binary_grid_neighbor_count_checker.sv
verif/tb_binary_grid_neighbor_count.sv
